// File: sv/assert_macros.svh
// assertion macros used by the top level rtl of the interval lookup block
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/stil_pkg.sv
// shared constants, codes and control structs of the interval lookup block
// no dependencies
package stil_pkg;

  // default sizes
  localparam int unsigned DEF_TABLE_DEPTH = 1024;
  localparam int unsigned DEF_VALUE_WIDTH = 32;

  // fixed field widths
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned POS_W      = 11;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned OUT_DATA_W = ((2 * POS_W + 7) / 8) * 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOOKUP_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_MATCH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT  = 2'd2;

  // lookup modes, the unused code acts as right mode
  localparam logic [MODE_W-1:0] MODE_NEAREST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RIGHT   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LEFT    = 2'd2;

  // item kinds
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // configuration registers
  typedef struct packed {
    logic [MODE_W-1:0] lookup_mode;
    logic              report_match;
    logic [CNT_W-1:0]  entry_count;
  } cfg_t;

  // controller to datapath strobes
  typedef struct packed {
    logic write;     // store a load item into the table
    logic start;     // latch query, read last valid entry
    logic chk_last;  // compare against last entry, start search
    logic step;      // one halving step
    logic found;     // evaluate the found entry
    logic prev;      // latch distance to the entry before
    logic pick;      // choose between found and previous
    logic emit;      // move result into the output register
  } cmd_t;

  // datapath to controller flags
  typedef struct packed {
    logic above_last;
    logic search_done;
    logic need_prev;
    logic out_free;
  } status_t;

endpackage

// File: sv/stil_ram.sv
// generic single-port ram with registered read
// no dependencies
module stil_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/stil_ctrl.sv
// sequencer of the interval lookup: one query at a time through the search
// depends on stil_pkg
module stil_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_query_i,
  output logic              in_ready_o,
  input  stil_pkg::status_t status_i,
  output stil_pkg::cmd_t    cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_LAST  = 7'b0000010,
    ST_SRCH  = 7'b0000100,
    ST_FOUND = 7'b0001000,
    ST_PREV  = 7'b0010000,
    ST_PICK  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // next state and strobes
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_query_i) begin
            cmd_o.start = 1'b1;
            state_d     = ST_LAST;
          end else begin
            cmd_o.write = 1'b1;
          end
        end
      end
      ST_LAST: begin
        cmd_o.chk_last = 1'b1;
        state_d        = status_i.above_last ? ST_DONE : ST_SRCH;
      end
      ST_SRCH: begin
        cmd_o.step = 1'b1;
        if (status_i.search_done) begin
          state_d = ST_FOUND;
        end
      end
      ST_FOUND: begin
        cmd_o.found = 1'b1;
        state_d     = status_i.need_prev ? ST_PREV : ST_DONE;
      end
      ST_PREV: begin
        cmd_o.prev = 1'b1;
        state_d    = ST_PICK;
      end
      ST_PICK: begin
        cmd_o.pick = 1'b1;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: sv/stil_dpath.sv
// datapath of the interval lookup: table ram, search bounds, distances, output register
// depends on stil_pkg and stil_ram
module stil_dpath #(
  parameter int unsigned TABLE_DEPTH = stil_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned VALUE_WIDTH = stil_pkg::DEF_VALUE_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  stil_pkg::cmd_t                cmd_i,
  output stil_pkg::status_t             status_o,
  input  stil_pkg::cfg_t                cfg_i,
  input  logic [stil_pkg::IDX_W-1:0]    entry_index_i,
  input  logic signed [VALUE_WIDTH-1:0] sample_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [stil_pkg::POS_W-1:0]    position_o,
  output logic [stil_pkg::POS_W-1:0]    match_position_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned IW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned VW = VALUE_WIDTH;
  localparam int unsigned PW = stil_pkg::POS_W;

  // exact distance between two signed values
  function automatic logic [VW:0] abs_diff(input logic signed [VW-1:0] a,
                                           input logic signed [VW-1:0] b);
    logic signed [VW:0] ae;
    logic signed [VW:0] be;
    ae = {a[VW-1], a};
    be = {b[VW-1], b};
    return (a < b) ? (be - ae) : (ae - be);
  endfunction

  logic signed [VW-1:0] q_q;
  logic [IW-1:0]        n_q, lo_q, hi_q, pos_q;
  logic [IW-1:0]        n_cfg;
  logic [stil_pkg::MODE_W-1:0] mode_q;
  logic                 rm_q;
  logic [VW:0]          dist_found_q, dist_prev_q;
  logic [PW-1:0]        res_pos_q, res_match_q;
  logic                 out_valid_q;
  logic [PW-1:0]        out_pos_q, out_match_q;

  logic [VW-1:0]        rd;
  logic signed [VW-1:0] rd_s;
  logic                 ram_we;
  logic [AW-1:0]        ram_addr;
  logic [IW:0]          cur_sum, nxt_sum;
  logic [IW-1:0]        mid, lo_n, hi_n, pos_n;
  logic                 rd_lt_q, step_done;
  logic [PW-1:0]        pos_p, pos_m1;

  // valid count with out-of-range values folded in
  always_comb begin
    if (cfg_i.entry_count == '0) begin
      n_cfg = IW'(1);
    end else if (32'(cfg_i.entry_count) > TABLE_DEPTH) begin
      n_cfg = IW'(TABLE_DEPTH);
    end else begin
      n_cfg = IW'(cfg_i.entry_count);
    end
  end

  // halving step
  assign rd_s      = $signed(rd);
  assign rd_lt_q   = rd_s < q_q;
  assign cur_sum   = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid       = cur_sum[IW:1];
  assign lo_n      = rd_lt_q ? (mid + IW'(1)) : lo_q;
  assign hi_n      = rd_lt_q ? hi_q : mid;
  assign nxt_sum   = {1'b0, lo_n} + {1'b0, hi_n};
  assign step_done = (lo_n >= hi_n);
  assign pos_n     = (lo_n < n_q) ? lo_n : (n_q - IW'(1));
  assign pos_p     = PW'(pos_q);
  assign pos_m1    = pos_p - PW'(1);

  // ram address and write enable
  assign ram_we = cmd_i.write && (32'(entry_index_i) < TABLE_DEPTH);
  always_comb begin
    if (cmd_i.write) begin
      ram_addr = AW'(entry_index_i);
    end else if (cmd_i.start) begin
      ram_addr = AW'(n_cfg - IW'(1));
    end else if (cmd_i.chk_last) begin
      ram_addr = AW'(n_q >> 1);
    end else if (cmd_i.step) begin
      ram_addr = step_done ? AW'(pos_n) : AW'(nxt_sum[IW:1]);
    end else if (cmd_i.found) begin
      ram_addr = AW'(pos_q - IW'(1));
    end else begin
      ram_addr = '0;
    end
  end

  stil_ram #(
    .WIDTH (VW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (sample_value_i),
    .rdata_o (rd)
  );

  // query, bounds and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      q_q    <= sample_value_i;
      n_q    <= n_cfg;
      mode_q <= cfg_i.lookup_mode;
      rm_q   <= cfg_i.report_match;
    end
    if (cmd_i.chk_last) begin
      lo_q        <= '0;
      hi_q        <= n_q;
      res_pos_q   <= PW'(n_q - IW'(1));
      res_match_q <= '0;
    end
    if (cmd_i.step) begin
      lo_q  <= lo_n;
      hi_q  <= hi_n;
      pos_q <= pos_n;
    end
    if (cmd_i.found) begin
      dist_found_q <= abs_diff(q_q, rd_s);
      res_match_q  <= (rm_q && (rd_s == q_q)) ? (pos_p + PW'(1)) : '0;
      res_pos_q    <= ((mode_q == stil_pkg::MODE_LEFT) && (q_q < rd_s)) ? pos_m1 : pos_p;
    end
    if (cmd_i.prev) begin
      dist_prev_q <= abs_diff(q_q, rd_s);
    end
    if (cmd_i.pick) begin
      res_pos_q <= (dist_prev_q < dist_found_q) ? pos_m1 : pos_p;
    end
    if (cmd_i.emit) begin
      out_pos_q   <= res_pos_q;
      out_match_q <= res_match_q;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // flags for the controller
  assign status_o.above_last  = rd_lt_q;
  assign status_o.search_done = step_done;
  assign status_o.need_prev   = (mode_q == stil_pkg::MODE_NEAREST) && (pos_q != '0);
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign position_o       = out_pos_q;
  assign match_position_o = out_match_q;

endmodule

// File: sv/sorted_table_interval_lookup_core.sv
// top level of the sorted table interval lookup: config registers, stream ports
// depends on stil_pkg, stil_ctrl, stil_dpath, stil_ram and assert_macros.svh
//
//  port group   dir  handshake                     contents
//  s_axis       in   s_axis_tvalid/s_axis_tready   load or query item
//  m_axis       out  m_axis_tvalid/m_axis_tready   one result per query
//  cfg          in   cfg_we_i                      register writes, no wait
//
// a load item gives no result and leaves the block ready for the next item
// a query first reads the last valid entry; a query above it skips the search
// else a binary search runs; nearest mode may read the entry before the found one
// the single-port table ram gives one registered read per halving step
// a query is held in the done state while the output register is full and not taken
// reset clears state, config and output valid; the table is undefined until loaded
`include "assert_macros.svh"

module sorted_table_interval_lookup_core #(
  parameter int unsigned TABLE_DEPTH = stil_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned VALUE_WIDTH = stil_pkg::DEF_VALUE_WIDTH,
  localparam int unsigned IN_DATA_W = ((stil_pkg::IDX_W + VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // entry_index, sample_value
  input  logic [IN_DATA_W-1:0]              s_axis_tdata,
  // req_type
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // position, match_position
  output logic [stil_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [stil_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [stil_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  localparam int unsigned PW = stil_pkg::POS_W;

  stil_pkg::cfg_t    cfg_q;
  stil_pkg::cmd_t    cmd;
  stil_pkg::status_t status;
  logic [stil_pkg::IDX_W-1:0]    entry_index;
  logic signed [VALUE_WIDTH-1:0] sample_value;
  logic [PW-1:0]                 position, match_position;
  logic                          query_acc;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lookup_mode  <= stil_pkg::MODE_NEAREST;
      cfg_q.report_match <= 1'b0;
      cfg_q.entry_count  <= stil_pkg::CNT_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        stil_pkg::CFG_LOOKUP_MODE:  cfg_q.lookup_mode  <= cfg_wdata_i[stil_pkg::MODE_W-1:0];
        stil_pkg::CFG_REPORT_MATCH: cfg_q.report_match <= cfg_wdata_i[0];
        stil_pkg::CFG_ENTRY_COUNT:  cfg_q.entry_count  <= cfg_wdata_i[stil_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // unpack the input item
  assign entry_index  = s_axis_tdata[stil_pkg::IDX_W-1:0];
  assign sample_value = $signed(s_axis_tdata[stil_pkg::IDX_W +: VALUE_WIDTH]);

  stil_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_query_i (s_axis_tuser == stil_pkg::REQ_QUERY),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  stil_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_i            (cfg_q),
    .entry_index_i    (entry_index),
    .sample_value_i   (sample_value),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .position_o       (position),
    .match_position_o (match_position)
  );

  // pack the result item
  assign m_axis_tdata = stil_pkg::OUT_DATA_W'({match_position, position});

  // query item taken at this edge
  assign query_acc = s_axis_tvalid && s_axis_tready &&
                     (s_axis_tuser == stil_pkg::REQ_QUERY);

  // a new result appears only after the controller moved one out
  `ASSERT_IMPLIES(a_out_from_emit, $rose(m_axis_tvalid), $past(cmd.emit), "result without emit")
  // the output register is never overwritten while a result waits
  `ASSERT_IMPLIES(a_emit_when_free, cmd.emit, status.out_free, "emit into full output")
  // an accepted query keeps the block busy
  `ASSERT_NEXT(a_busy_after_query, query_acc, !s_axis_tready, "ready right after a query")

endmodule

// File: test/sorted_table_interval_lookup_core_tb.sv
// self-checking testbench for sorted_table_interval_lookup_core: table loads, queries in all modes
// depends on stil_pkg and the rtl of the block; predicts every lookup result in a scoreboard class
import stil_pkg::*;

typedef struct {
  logic [POS_W-1:0] position;
  logic [POS_W-1:0] match_position;
} lookup_result_t;

// mirror of the table and registers, predicts and checks lookup results
class lookup_scoreboard;
  logic signed [DEF_VALUE_WIDTH-1:0] times [DEF_TABLE_DEPTH];
  logic [MODE_W-1:0] lookup_mode;
  logic              report_match;
  logic [CNT_W-1:0]  entry_count;
  lookup_result_t    expected_lookups [$];
  int                errors;

  function new();
    lookup_mode  = MODE_NEAREST;
    report_match = 1'b0;
    entry_count  = 1;
    errors       = 0;
    foreach (times[i]) times[i] = '0;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_LOOKUP_MODE:  lookup_mode  = data[MODE_W-1:0];
      CFG_REPORT_MATCH: report_match = data[0];
      CFG_ENTRY_COUNT:  entry_count  = data[CNT_W-1:0];
      default: ;
    endcase
  endfunction

  function int active_entries();
    int n;
    n = entry_count;
    if (n < 1) n = 1;
    if (n > DEF_TABLE_DEPTH) n = DEF_TABLE_DEPTH;
    return n;
  endfunction

  // exact distance, wider than the values
  function longint distance(logic signed [DEF_VALUE_WIDTH-1:0] a,
                            logic signed [DEF_VALUE_WIDTH-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return (d < 0) ? -d : d;
  endfunction

  // binary search for first entry not less than the query, then mode adjustment
  function lookup_result_t find_interval(logic signed [DEF_VALUE_WIDTH-1:0] q);
    lookup_result_t r;
    int n, lo, hi, mid, pos, sel;
    logic signed [DEF_VALUE_WIDTH-1:0] found;
    n = active_entries();
    r.match_position = '0;
    if (times[n-1] < q) begin
      sel = n - 1;
    end else begin
      lo = 0;
      hi = n;
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (times[mid] < q) lo = mid + 1;
        else hi = mid;
      end
      pos = (lo < n) ? lo : n - 1;
      found = times[pos];
      if (report_match && found == q) r.match_position = POS_W'(pos + 1);
      sel = pos;
      if (lookup_mode == MODE_NEAREST && pos > 0) begin
        // step back only when the entry before is strictly closer
        if (distance(q, times[pos-1]) < distance(q, found)) sel = pos - 1;
      end else if (lookup_mode == MODE_LEFT && q < found) begin
        sel = pos - 1;
      end
    end
    r.position = POS_W'(sel);
    return r;
  endfunction

  // accepted input item: update the table or queue the lookup result
  function void note_item(logic kind, logic [IDX_W-1:0] idx,
                          logic signed [DEF_VALUE_WIDTH-1:0] val);
    if (kind == REQ_LOAD) times[idx] = val;
    else expected_lookups.push_back(find_interval(val));
  endfunction

  // accepted result item against the oldest expectation
  function void check_result(logic [OUT_DATA_W-1:0] word);
    lookup_result_t e;
    logic [POS_W-1:0] pos, hit;
    pos = word[POS_W-1:0];
    hit = word[2*POS_W-1:POS_W];
    if (expected_lookups.size() == 0) begin
      $display("%0t: unexpected result position %0d match_position %0d", $time, pos, hit);
      errors++;
      return;
    end
    e = expected_lookups.pop_front();
    if (pos !== e.position) begin
      $display("%0t: position expected %0d actual %0d", $time, e.position, pos);
      errors++;
    end
    if (hit !== e.match_position) begin
      $display("%0t: match_position expected %0d actual %0d", $time, e.match_position, hit);
      errors++;
    end
  endfunction

  function int pending();
    return expected_lookups.size();
  endfunction
endclass

module sorted_table_interval_lookup_core_tb;

  localparam int unsigned IN_DATA_W = ((IDX_W + DEF_VALUE_WIDTH + 7) / 8) * 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [MODE_W-1:0]    MODE_SPARE = 2'd3;
  localparam int ITEM_BUDGET = 1150;
  localparam int SETTLE_CYCLES = 24;
  localparam int SHAPE_DENSE = 0;
  localparam int SHAPE_WIDE = 1;
  localparam int SHAPE_SHUFFLED = 2;
  localparam logic [31:0] VAL_MIN = 32'h8000_0000;
  localparam logic [31:0] VAL_MAX = 32'h7fff_ffff;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i;

  lookup_scoreboard sb;
  bit written [DEF_TABLE_DEPTH];
  int items_sent;
  bit src_gaps;
  bit sink_stalls;
  int stall_left;

  sorted_table_interval_lookup_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // clock
  always #4 clk_i = ~clk_i;

  // gap length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // result side: check accepted items, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if (!rst_ni || !sink_stalls) begin
      m_axis_tready <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // one input item, held until accepted
  task automatic send_item(logic kind, logic [IDX_W-1:0] idx, logic [31:0] val);
    int gap;
    gap = src_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= IN_DATA_W'({val, idx});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_item(kind, idx, val);
    if (kind == REQ_LOAD) written[idx] = 1'b1;
    items_sent++;
  endtask

  task automatic ask(logic [31:0] val);
    send_item(REQ_QUERY, IDX_W'($urandom), val);
  endtask

  // drain all results, then let the block settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  // all three registers, junk in the unused upper bits
  task automatic program_regs(logic [MODE_W-1:0] mode, logic report, logic [CNT_W-1:0] count);
    logic [CFG_DATA_W-1:0] d;
    if ($urandom_range(0, 7) == 0) cfg_write(CFG_SPARE, CFG_DATA_W'($urandom));
    d = CFG_DATA_W'($urandom);
    d[MODE_W-1:0] = mode;
    cfg_write(CFG_LOOKUP_MODE, d);
    d = CFG_DATA_W'($urandom);
    d[0] = report;
    cfg_write(CFG_REPORT_MATCH, d);
    cfg_write(CFG_ENTRY_COUNT, count);
    cfg_we_i <= 1'b0;
  endtask

  // fill entries 0..n-1, sorted unless shuffled
  task automatic load_table(int n, int shape);
    int vals [$];
    longint v;
    v = longint'(int'($urandom) >>> 4);
    for (int i = 0; i < n; i++) begin
      case (shape)
        SHAPE_DENSE: begin
          vals.push_back(int'(v));
          v += $urandom_range(0, 3);
        end
        default: vals.push_back(int'($urandom));
      endcase
    end
    if (shape == SHAPE_WIDE) begin
      vals.sort();
      if ($urandom_range(0, 3) == 0) vals[0] = int'(VAL_MIN);
      if ($urandom_range(0, 3) == 0) vals[n-1] = int'(VAL_MAX);
    end
    for (int i = 0; i < n; i++) send_item(REQ_LOAD, IDX_W'(i), vals[i]);
  endtask

  // query biased toward entries, their neighbors, midpoints and extremes
  function automatic logic [31:0] pick_query(int n);
    int k;
    longint a, b;
    k = $urandom_range(0, n - 1);
    case ($urandom_range(0, 9))
      0, 1, 2: return sb.times[k];
      3: return sb.times[k] + 1;
      4: return sb.times[k] - 1;
      5: begin
        if (k + 1 >= n) return $urandom;
        a = longint'(sb.times[k]);
        b = longint'(sb.times[k+1]);
        return 32'((a + b) >>> 1);
      end
      6: return VAL_MIN;
      7: return VAL_MAX;
      default: return $urandom;
    endcase
  endfunction

  // timeout
  initial begin
    #12000000;
    $display("sorted_table_interval_lookup_core_tb: errors");
    $finish;
  end

  initial begin
    int phase, n, shape, nq;
    logic [CNT_W-1:0] count;
    bit reload;
    sb = new();
    clk_i = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = REQ_LOAD;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_LOOKUP_MODE;
    cfg_wdata_i = '0;
    items_sent = 0;
    src_gaps = 1'b0;
    sink_stalls = 1'b0;
    stall_left = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset settings, single entry at the minimum: exact hit and queries above it
    send_item(REQ_LOAD, '0, VAL_MIN);
    ask(VAL_MIN);
    ask(32'h0);
    ask(VAL_MAX);

    // four entries, two near the extremes, nearest mode with matches
    wait_idle();
    program_regs(MODE_NEAREST, 1'b1, 11'd4);
    send_item(REQ_LOAD, 10'd0, 32'h8000_0001);
    send_item(REQ_LOAD, 10'd1, -32'sd327680);
    send_item(REQ_LOAD, 10'd2, 32'sd327680);
    send_item(REQ_LOAD, 10'd3, 32'h7fff_fffe);
    ask(VAL_MIN);
    ask(32'h8000_0001);
    ask(-32'sd65536);   // entry before strictly closer
    ask(32'h0);         // equal distance keeps the found entry
    ask(VAL_MAX);       // above the last entry

    wait_idle();
    program_regs(MODE_RIGHT, 1'b1, 11'd4);
    ask(32'sd327680);
    ask(32'h1);

    // left mode, including below the first entry
    wait_idle();
    program_regs(MODE_LEFT, 1'b0, 11'd4);
    ask(VAL_MIN);
    ask(32'h0);
    ask(32'sd327680);

    // unused mode code acts as right mode
    wait_idle();
    program_regs(MODE_SPARE, 1'b1, 11'd4);
    ask(32'h0);

    // random phases: a fresh table unless the full table is already loaded, then queries with some noise loads
    phase = 0;
    while (items_sent < ITEM_BUDGET || phase < 6) begin
      wait_idle();
      phase++;
      case (phase)
        2: count = 11'd1024;
        3: count = 11'd2047;   // clamps to the full table
        5: count = 11'd0;      // acts as one entry
        default: count = ($urandom_range(0, 9) < 7) ? CNT_W'($urandom_range(1, 16))
                                                     : CNT_W'($urandom_range(17, 100));
      endcase
      n = (count < 1) ? 1 : ((count > DEF_TABLE_DEPTH) ? DEF_TABLE_DEPTH : count);
      src_gaps = (phase == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      sink_stalls = (phase == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      program_regs(MODE_W'($urandom_range(0, 3)), 1'($urandom), count);
      shape = ($urandom_range(0, 9) == 0) ? SHAPE_SHUFFLED
                                          : (($urandom_range(0, 1) == 0) ? SHAPE_DENSE
                                                                         : SHAPE_WIDE);
      reload = (n < DEF_TABLE_DEPTH);
      for (int i = 0; i < n; i++) if (!written[i]) reload = 1'b1;
      if (reload) load_table(n, shape);
      nq = (n == DEF_TABLE_DEPTH) ? 20 : $urandom_range(12, 30);
      for (int j = 0; j < nq; j++) begin
        if ($urandom_range(0, 29) == 0 || (phase == 1 && j == 10)) begin
          // hold the sender until every lookup has come back
          s_axis_tvalid <= 1'b0;
          @(posedge clk_i);
          while (sb.pending() != 0) @(posedge clk_i);
        end
        if ($urandom_range(0, 19) == 0)
          send_item(REQ_LOAD, IDX_W'($urandom), $urandom);
        ask(pick_query(n));
      end
    end

    // drain and settle before the verdict
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("sorted_table_interval_lookup_core_tb: clean");
    end else begin
      $display("sorted_table_interval_lookup_core_tb: errors");
    end
    $finish;
  end

endmodule
